/* src/numeric_type_saturating_cast_macros.svh */
// Assertion macros used by the top-level RTL.
`ifndef NUMERIC_TYPE_SATURATING_CAST_MACROS_SVH
`define NUMERIC_TYPE_SATURATING_CAST_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define NTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ntsc assertion failed");

// Antecedent implies consequent in the same cycle.
`define NTSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ntsc assertion failed");

`endif

/* src/ntsc_pkg.sv */
`timescale 1ns / 1ps
package ntsc_pkg;

  // Source type codes
  localparam logic [3:0] ST_DOUBLE  = 4'd0;
  localparam logic [3:0] ST_SINGLE  = 4'd1;
  localparam logic [3:0] ST_LOGICAL = 4'd2;
  localparam logic [3:0] ST_INT8    = 4'd3;
  localparam logic [3:0] ST_INT64   = 4'd6;
  localparam logic [3:0] ST_UINT8   = 4'd7;
  localparam logic [3:0] ST_UINT64  = 4'd10;
  localparam logic [3:0] ST_CHAR    = 4'd11;

  // Target type codes
  localparam logic [3:0] TT_DOUBLE  = 4'd0;
  localparam logic [3:0] TT_SINGLE  = 4'd1;
  localparam logic [3:0] TT_INT8    = 4'd2;
  localparam logic [3:0] TT_INT64   = 4'd5;
  localparam logic [3:0] TT_UINT8   = 4'd6;
  localparam logic [3:0] TT_UINT64  = 4'd9;

  // Integer width codes (8/16/32/64)
  localparam logic [1:0] W8  = 2'd0;
  localparam logic [1:0] W16 = 2'd1;
  localparam logic [1:0] W32 = 2'd2;
  localparam logic [1:0] W64 = 2'd3;

  // Decoded source: word is the masked raw element (same), final double bits
  // (direct) or an integer magnitude scaled by 2^k.
  typedef struct packed {
    logic              same;
    logic              direct;
    logic [3:0]        tt;
    logic              sign;
    logic signed [8:0] k;
    logic [63:0]       word;
  } dec_t;

  // Normalized: word has its leading one at bit 63, expo is biased.
  typedef struct packed {
    logic        same;
    logic        direct;
    logic [3:0]  tt;
    logic        sign;
    logic [10:0] expo;
    logic [63:0] word;
  } norm_t;

  // Double bits (or the passthrough element).
  typedef struct packed {
    logic        same;
    logic [3:0]  tt;
    logic [63:0] word;
  } dbl_t;

  function automatic logic [63:0] width_mask(input logic [1:0] w);
    logic [63:0] m;
    case (w)
      W8:      m = 64'h0000_0000_0000_00FF;
      W16:     m = 64'h0000_0000_0000_FFFF;
      W32:     m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* src/ntsc_decode.sv */
`timescale 1ns / 1ps
module ntsc_decode import ntsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [3:0]  source_type_i,
  input  logic [63:0] source_bits_i,
  input  logic [3:0]  target_type_i,
  output logic        valid_o,
  output dec_t        dec_o
);

  logic        valid_q;
  dec_t        dec_d, dec_q;
  logic [63:0] m, x;
  logic [1:0]  w;
  logic        msb, same;
  logic [7:0]  fex;
  logic [22:0] fman;

  always_comb begin
    m    = 64'd0;
    x    = 64'd0;
    w    = W8;
    msb  = 1'b0;
    fex  = source_bits_i[30:23];
    fman = source_bits_i[22:0];
    same = ((target_type_i <= TT_SINGLE) && (source_type_i == target_type_i)) ||
           ((target_type_i >= TT_INT8) && (target_type_i <= TT_UINT64) &&
            (source_type_i == 4'(target_type_i + 4'd1)));
    dec_d        = '0;
    dec_d.tt     = target_type_i;
    dec_d.same   = same;
    if (source_type_i == ST_DOUBLE) begin
      dec_d.direct = 1'b1;
      dec_d.word   = source_bits_i;
    end else if (source_type_i == ST_SINGLE) begin
      dec_d.sign = source_bits_i[31];
      if (fex == 8'hFF) begin
        dec_d.direct = 1'b1;
        dec_d.word   = {source_bits_i[31], 11'h7FF, (fman != 23'd0), fman[21:0], 29'd0};
        dec_d.word[51] = dec_d.word[51] | fman[22];
      end else if (fex == 8'd0 && fman == 23'd0) begin
        dec_d.direct = 1'b1;
        dec_d.word   = {source_bits_i[31], 63'd0};
      end else if (fex == 8'd0) begin
        dec_d.word = {41'd0, fman};
        dec_d.k    = -9'sd149;
      end else begin
        dec_d.word = {40'd0, 1'b1, fman};
        dec_d.k    = $signed({1'b0, fex}) - 9'sd150;
      end
    end else if (source_type_i == ST_LOGICAL) begin
      dec_d.word = {63'd0, |source_bits_i[7:0]};
    end else if (source_type_i >= ST_INT8 && source_type_i <= ST_INT64) begin
      w   = 2'(source_type_i - ST_INT8);
      m   = width_mask(w);
      x   = source_bits_i & m;
      msb = |(x & ~(m >> 1));
      dec_d.sign = msb;
      dec_d.word = msb ? ((64'd0 - x) & m) : x;
    end else if (source_type_i >= ST_UINT8 && source_type_i <= ST_UINT64) begin
      w = 2'(source_type_i - ST_UINT8);
      dec_d.word = source_bits_i & width_mask(w);
    end else if (source_type_i == ST_CHAR) begin
      dec_d.word = {56'd0, source_bits_i[7:0]};
    end else begin
      dec_d.direct = 1'b1;
      dec_d.word   = 64'd0;
    end
    // zero integer magnitude: plain +0.0
    if (!dec_d.direct && dec_d.word == 64'd0) begin
      dec_d.direct = 1'b1;
    end
    // same-type passthrough keeps the masked raw element
    if (same) begin
      case (source_type_i)
        ST_DOUBLE: dec_d.word = source_bits_i;
        ST_SINGLE: dec_d.word = {32'd0, source_bits_i[31:0]};
        default: begin
          w = 2'(source_type_i - (source_type_i >= ST_UINT8 ? ST_UINT8 : ST_INT8));
          dec_d.word = source_bits_i & width_mask(w);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

/* src/ntsc_pack.sv */
`timescale 1ns / 1ps
module ntsc_pack import ntsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  dec_t  dec_i,
  output logic  valid_o,
  output dbl_t  dbl_o
);

  logic        nrm_valid_q, dbl_valid_q;
  norm_t       nrm_d, nrm_q;
  dbl_t        dbl_d, dbl_q;
  logic [5:0]  lz;
  logic [52:0] keep;
  logic        up;
  logic [53:0] sum;
  logic [10:0] expo;

  // Stage: leading-zero count and normalize
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (dec_i.word[i]) begin
        lz = 6'(63 - i);
      end
    end
    nrm_d.same   = dec_i.same;
    nrm_d.direct = dec_i.direct;
    nrm_d.tt     = dec_i.tt;
    nrm_d.sign   = dec_i.sign;
    nrm_d.expo   = 11'(11'd1086 + {{2{dec_i.k[8]}}, dec_i.k} - {5'd0, lz});
    nrm_d.word   = (dec_i.direct || dec_i.same) ? dec_i.word : (dec_i.word << lz);
  end

  // Stage: round to 53 bits, nearest even
  always_comb begin
    keep = nrm_q.word[63:11];
    up   = nrm_q.word[10] & ((|nrm_q.word[9:0]) | keep[0]);
    sum  = {1'b0, keep} + {53'd0, up};
    expo = nrm_q.expo + {10'd0, sum[53]};
    dbl_d.same = nrm_q.same;
    dbl_d.tt   = nrm_q.tt;
    if (nrm_q.direct || nrm_q.same) begin
      dbl_d.word = nrm_q.word;
    end else begin
      dbl_d.word = {nrm_q.sign, expo, sum[53] ? 52'd0 : sum[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_valid_q <= 1'b0;
      dbl_valid_q <= 1'b0;
    end else if (en_i) begin
      nrm_valid_q <= valid_i;
      dbl_valid_q <= nrm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_q <= nrm_d;
      dbl_q <= dbl_d;
    end
  end

  assign valid_o = dbl_valid_q;
  assign dbl_o   = dbl_q;

endmodule

/* src/ntsc_narrow.sv */
`timescale 1ns / 1ps
module ntsc_narrow import ntsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  dbl_t        dbl_i,
  output logic        valid_o,
  output logic [63:0] result_o
);

  logic        valid_q;
  logic [63:0] result_d, result_q;
  logic        s, nan, inf;
  logic [10:0] ex;
  logic [51:0] man;
  logic [63:0] sigx;
  // single target
  logic [5:0]  sh;
  logic [63:0] kp, rems;
  logic        g, stk, up;
  logic [24:0] keep2;
  logic [11:0] fe, fe_f;
  logic [31:0] sres;
  // integer targets
  logic        ovf;
  logic [63:0] mag, r, m, lim;
  logic [1:0]  w;
  logic [63:0] ires;

  always_comb begin
    s    = dbl_i.word[63];
    ex   = dbl_i.word[62:52];
    man  = dbl_i.word[51:0];
    nan  = (ex == 11'h7FF) && (man != 52'd0);
    inf  = (ex == 11'h7FF) && (man == 52'd0);
    sigx = {11'd0, 1'b1, man};

    // binary64 -> binary32, round to nearest even
    sh    = (ex >= 11'd897) ? 6'd29 : 6'(11'd926 - ex);
    kp    = sigx >> sh;
    rems  = sigx << (7'd64 - {1'b0, sh});
    g     = rems[63];
    stk   = |rems[62:0];
    up    = g & (stk | kp[0]);
    keep2 = kp[24:0] + {24'd0, up};
    fe    = {1'b0, ex} - 12'd896;
    fe_f  = fe + {11'd0, keep2[24]};
    if (ex == 11'h7FF) begin
      sres = inf ? {s, 8'hFF, 23'd0} : {s, 8'hFF, 1'b1, man[50:29]};
    end else if (ex < 11'd863) begin
      sres = {s, 31'd0};
    end else if (ex < 11'd897) begin
      sres = {s, 6'd0, keep2};
    end else if (fe_f >= 12'd255) begin
      sres = {s, 8'hFF, 23'd0};
    end else begin
      sres = {s, fe_f[7:0], keep2[22:0]};
    end

    // binary64 -> integer magnitude, half away from zero
    ovf = inf || (ex >= 11'd1087);
    r   = 64'd0;
    if (ex < 11'd1022) begin
      mag = 64'd0;
    end else if (ex >= 11'd1075) begin
      mag = sigx << 4'(ex - 11'd1075);
    end else begin
      r   = (sigx >> 6'(11'd1074 - ex)) + 64'd1;
      mag = r >> 1;
    end
    w   = 2'(dbl_i.tt - TT_INT8);
    m   = width_mask(w);
    lim = (m >> 1) + 64'd1;
    if (nan) begin
      ires = 64'd0;
    end else if (dbl_i.tt <= TT_INT64) begin
      if (s) begin
        ires = (ovf || mag > lim) ? lim : ((64'd0 - mag) & m);
      end else begin
        ires = (ovf || mag >= lim) ? (m >> 1) : mag;
      end
    end else begin
      if (s) begin
        ires = 64'd0;
      end else begin
        ires = (ovf || ((w != W64) && mag > m)) ? m : mag;
      end
    end

    if (dbl_i.same) begin
      result_d = dbl_i.word;
    end else if (dbl_i.tt == TT_DOUBLE) begin
      result_d = dbl_i.word;
    end else if (dbl_i.tt == TT_SINGLE) begin
      result_d = {32'd0, sres};
    end else if (dbl_i.tt <= TT_UINT64) begin
      result_d = ires;
    end else begin
      result_d = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* src/numeric_type_saturating_cast.sv */
`timescale 1ns / 1ps
// Saturating numeric cast. One element per transfer in, one per transfer out;
// a new element is taken every cycle while the output side does not stall. The
// element is decoded and masked, normalized by a 64-bit leading-zero count and
// shift, rounded to an IEEE double (the result for double targets), and then
// narrowed in the last stage to single (nearest even) or to an integer (half
// away from zero, NaN to zero, saturating). Same-type casts pass the masked
// element through. The four stages move together; the input is stalled only
// while a finished result waits on a stalled output.
`include "numeric_type_saturating_cast_macros.svh"
module numeric_type_saturating_cast import ntsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  source_type_i,
  input  logic [63:0] source_bits_i,
  input  logic [3:0]  target_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_bits_o
);

  logic  adv;
  logic  dec_valid, dbl_valid;
  dec_t  dec;
  dbl_t  dbl;

  // whole pipe advances unless the result register is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  ntsc_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (in_valid_i),
    .source_type_i (source_type_i),
    .source_bits_i (source_bits_i),
    .target_type_i (target_type_i),
    .valid_o       (dec_valid),
    .dec_o         (dec)
  );

  ntsc_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (dbl_valid),
    .dbl_o   (dbl)
  );

  ntsc_narrow u_narrow (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (dbl_valid),
    .dbl_i    (dbl),
    .valid_o  (out_valid_o),
    .result_o (result_bits_o)
  );

  // an input transfer always lands in the decode stage
  `NTSC_ASSERT_NEXT(a_in_lands, in_valid_i && !in_stall_o, dec_valid)
  // unknown target gives zero
  `NTSC_ASSERT_NEXT(a_unknown_tt, adv && dbl_valid && dbl.tt > TT_UINT64 && !dbl.same, result_bits_o == 64'd0)
  // same-type element reaches the output untouched
  `NTSC_ASSERT_NEXT(a_same_pass, adv && dbl_valid && dbl.same, result_bits_o == $past(dbl.word))
  // stall is only raised by a waiting result
  `NTSC_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o)

endmodule
